// ===== sv/kwlex_pkg.sv =====
// ----------------------------------------------------------------------------
// kwlex_pkg
// Shared types, constants and keyword tables for the keyword lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package kwlex_pkg;

    // Sizing
    localparam int ID_WIDTH     = 32;
    localparam int MAX_WORD_LEN = 255;
    localparam int LEN_W        = $clog2(MAX_WORD_LEN + 1);
    localparam int NUM_KW       = 5;
    localparam int KW_MAXLEN    = 6;

    // Token kinds
    localparam logic [3:0] KIND_SPACE   = 4'd0;
    localparam logic [3:0] KIND_NEWLINE = 4'd1;
    localparam logic [3:0] KIND_LPAREN  = 4'd2;
    localparam logic [3:0] KIND_RPAREN  = 4'd3;
    localparam logic [3:0] KIND_LBRACE  = 4'd4;
    localparam logic [3:0] KIND_RBRACE  = 4'd5;
    localparam logic [3:0] KIND_EQUALS  = 4'd6;
    localparam logic [3:0] KIND_SEMI    = 4'd7;
    localparam logic [3:0] KIND_BANG    = 4'd8;
    localparam logic [3:0] KIND_KW_BASE = 4'd9;
    localparam logic [3:0] KIND_INTLIT  = 4'd14;
    localparam logic [3:0] KIND_IDENT   = 4'd15;

    // Keywords: int, return, bool, false, true
    localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAXLEN] = '{
        '{8'h69, 8'h6e, 8'h74, 8'h00, 8'h00, 8'h00},
        '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6e},
        '{8'h62, 8'h6f, 8'h6f, 8'h6c, 8'h00, 8'h00},
        '{8'h66, 8'h61, 8'h6c, 8'h73, 8'h65, 8'h00},
        '{8'h74, 8'h72, 8'h75, 8'h65, 8'h00, 8'h00}
    };
    localparam logic [LEN_W-1:0] KW_LEN [NUM_KW] = '{
        LEN_W'(3), LEN_W'(6), LEN_W'(4), LEN_W'(5), LEN_W'(4)
    };

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } lex_in_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [31:0] token_id;
        logic [31:0] word_start;
        logic [7:0]  word_length;
        logic        last;
    } lex_out_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] kind;
    } delim_t;

    function automatic delim_t delim_decode(input logic [7:0] b);
        delim_t d;
        d.hit = 1'b1;
        case (b)
            8'h20:   d.kind = KIND_SPACE;
            8'h0a:   d.kind = KIND_NEWLINE;
            8'h28:   d.kind = KIND_LPAREN;
            8'h29:   d.kind = KIND_RPAREN;
            8'h7b:   d.kind = KIND_LBRACE;
            8'h7d:   d.kind = KIND_RBRACE;
            8'h3d:   d.kind = KIND_EQUALS;
            8'h3b:   d.kind = KIND_SEMI;
            8'h21:   d.kind = KIND_BANG;
            default: begin
                d.hit  = 1'b0;
                d.kind = KIND_SPACE;
            end
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== sv/keyword_lexer.sv =====
// ----------------------------------------------------------------------------
// keyword_lexer
// Byte-serial tokenizer: keywords, booleans, integer literals, identifiers
// and single-character delimiters, each reported with id, offset and length.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake           | word
//  --------+-----+---------------------+---------------------------------
//  s_      | in  | s_valid / s_ready   | lex_in_t  (byte, end-of-text)
//  m_      | out | m_valid / m_ready   | lex_out_t (kind, id, start, len)
//
//  One input word per cycle while s_ready is high. Its results land in a
//  three-entry output queue in the cycle it is taken; a delimiter that closes
//  a word yields two results, and the queue drains one result per cycle while
//  m_ready is high. s_ready is high while the queue holds at most one result.
//  Synchronous active-low reset: counter to 1, position and word cleared,
//  queue empty. m_ready low simply fills the queue and drops s_ready.
//
`default_nettype none

module keyword_lexer
    import kwlex_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire lex_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output lex_out_t      m_data
);

    // ---------------- lexer state ----------------
    logic [ID_WIDTH-1:0] id_counter_reg, id_counter_next;
    logic [LEN_W-1:0]    pend_len_reg, pend_len_next;
    logic                all_digits_reg, all_digits_next;
    logic [NUM_KW-1:0]   kw_cand_reg, kw_cand_next;
    logic [31:0]         byte_pos_reg, byte_pos_next;
    logic [31:0]         pend_start_reg, pend_start_next;

    // ---------------- output queue ----------------
    // q_reg[0] is the head; entries shift down on a pop.
    lex_out_t   q_reg [3];
    lex_out_t   q_next [3];
    logic [1:0] count_reg, count_next;

    logic       s_fire, m_fire;
    logic [1:0] push_n;
    lex_out_t   res0, res1;
    delim_t     dl;
    logic [3:0] word_kind;
    logic [63:0] id_cur_ext, id_inc_ext;
    logic [31:0] len_ext;
    logic [1:0] base;

    assign s_ready = (count_reg <= 2'd1);
    assign m_valid = (count_reg != 2'd0);
    assign m_data  = q_reg[0];
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;

    assign dl         = delim_decode(s_data.text_byte);
    assign id_cur_ext = 64'(id_counter_reg);
    assign id_inc_ext = 64'(id_counter_reg + ID_WIDTH'(1));
    assign len_ext    = 32'(pend_len_reg);

    // classify the pending word: first keyword whose text survived wins
    always_comb begin
        word_kind = all_digits_reg ? KIND_INTLIT : KIND_IDENT;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (kw_cand_reg[k] && pend_len_reg == KW_LEN[k]) begin
                word_kind = KIND_KW_BASE + 4'(k);
            end
        end
    end

    // ---------------- per-word step ----------------
    always_comb begin
        id_counter_next = id_counter_reg;
        pend_len_next   = pend_len_reg;
        all_digits_next = all_digits_reg;
        kw_cand_next    = kw_cand_reg;
        byte_pos_next   = byte_pos_reg;
        pend_start_next = pend_start_reg;
        push_n          = 2'd0;

        // pending word, as it would be emitted
        res0.token_kind  = word_kind;
        res0.token_id    = id_cur_ext[31:0];
        res0.word_start  = pend_start_reg;
        res0.word_length = len_ext[7:0];
        res0.last        = 1'b1;
        // the delimiter itself
        res1.token_kind  = dl.kind;
        res1.token_id    = id_cur_ext[31:0];
        res1.word_start  = byte_pos_reg;
        res1.word_length = 8'd1;
        res1.last        = 1'b1;

        if (s_fire) begin
            if (s_data.end_of_text) begin
                // flush a trailing word; position holds
                if (pend_len_reg != '0) begin
                    push_n          = 2'd1;
                    id_counter_next = id_counter_reg + ID_WIDTH'(1);
                    pend_len_next   = '0;
                    all_digits_next = 1'b1;
                    kw_cand_next    = '1;
                end
            end else if (dl.hit) begin
                if (pend_len_reg != '0) begin
                    // word takes the id after the delimiter's, goes out first
                    res0.token_id   = id_inc_ext[31:0];
                    res0.last       = 1'b0;
                    push_n          = 2'd2;
                    id_counter_next = id_counter_reg + ID_WIDTH'(2);
                end else begin
                    res0            = res1;
                    push_n          = 2'd1;
                    id_counter_next = id_counter_reg + ID_WIDTH'(1);
                end
                pend_len_next   = '0;
                all_digits_next = 1'b1;
                kw_cand_next    = '1;
                byte_pos_next   = byte_pos_reg + 32'd1;
            end else begin
                if (pend_len_reg == '0) begin
                    pend_start_next = byte_pos_reg;
                end
                for (int k = 0; k < NUM_KW; k++) begin
                    if (pend_len_reg >= KW_LEN[k]) begin
                        kw_cand_next[k] = 1'b0;
                    end else if (KW_TEXT[k][pend_len_reg[2:0]] != s_data.text_byte) begin
                        kw_cand_next[k] = 1'b0;
                    end
                end
                if (s_data.text_byte < 8'h30 || s_data.text_byte > 8'h39) begin
                    all_digits_next = 1'b0;
                end
                if (pend_len_reg < LEN_W'(MAX_WORD_LEN)) begin
                    pend_len_next = pend_len_reg + LEN_W'(1);
                end
                byte_pos_next = byte_pos_reg + 32'd1;
            end
        end
    end

    // ---------------- queue update ----------------
    always_comb begin
        base = count_reg - {1'b0, m_fire};
        q_next[0] = m_fire ? q_reg[1] : q_reg[0];
        q_next[1] = m_fire ? q_reg[2] : q_reg[1];
        q_next[2] = q_reg[2];
        for (int i = 0; i < 3; i++) begin
            if (push_n != 2'd0 && base == 2'(i)) begin
                q_next[i] = res0;
            end
            if (push_n == 2'd2 && base + 2'd1 == 2'(i)) begin
                q_next[i] = res1;
            end
        end
        count_next = base + push_n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_counter_reg <= ID_WIDTH'(1);
            pend_len_reg   <= '0;
            all_digits_reg <= 1'b1;
            kw_cand_reg    <= '1;
            byte_pos_reg   <= '0;
            pend_start_reg <= '0;
            count_reg      <= 2'd0;
        end else begin
            id_counter_reg <= id_counter_next;
            pend_len_reg   <= pend_len_next;
            all_digits_reg <= all_digits_next;
            kw_cand_reg    <= kw_cand_next;
            byte_pos_reg   <= byte_pos_next;
            pend_start_reg <= pend_start_next;
            count_reg      <= count_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    // ---------------- assertions ----------------
    // queue never overflows on a push
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |-> (3'(count_reg) - 3'(m_fire) + 3'(push_n)) <= 3'd3)
        else $error("output queue overflow");

    // a word that is not last always has its delimiter queued behind it
    a_pair_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last) |-> count_reg >= 2'd2)
        else $error("word result without its delimiter");

    // a two-result item shows up at the output next cycle
    a_pair_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && push_n == 2'd2) |=> (m_valid && count_reg >= 2'd2))
        else $error("two-result item not queued");

    // a delimiter always advances the id counter
    a_id_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !s_data.end_of_text && dl.hit) |=>
            id_counter_reg != $past(id_counter_reg))
        else $error("id counter did not advance on delimiter");

endmodule

`default_nettype wire
